### hdl/dvru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dvru_pkg;

   localparam int MAX_NODES    = 16;
   localparam int NODE_BITS    = $clog2(MAX_NODES);
   localparam int CNT_BITS     = $clog2(MAX_NODES + 1);
   localparam int ADDR_BITS    = 2 * NODE_BITS;
   localparam int MATRIX_DEPTH = 1 << ADDR_BITS;

   localparam int FIELD_BITS    = 5;
   localparam int COST_BITS     = 16;
   localparam int SUM_BITS      = COST_BITS + 1;
   localparam int HOP_BITS      = 5;
   localparam int OP_BITS       = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [COST_BITS-1:0]  COST_INF         = '1;
   localparam logic [COST_BITS-1:0]  CAP_RESET        = 16'd100;
   localparam logic [FIELD_BITS-1:0] MY_INDEX_RESET   = 5'd1;
   localparam logic [FIELD_BITS-1:0] NODE_COUNT_RESET = 5'd16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MY_INDEX   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NODE_COUNT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COST_CAP   = 2'd2;

   typedef enum logic [OP_BITS-1:0] {
      OP_SET_LINK     = 2'd0,
      OP_STORE_ADVERT = 2'd1,
      OP_RECOMPUTE    = 2'd2,
      OP_READ_ROUTE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      WR_SET_LINK,
      WR_ADVERT,
      WR_CLEAR,
      WR_BACK
   } wr_sel_type;

   typedef enum logic {
      RD_ROUTE,
      RD_RELAX
   } rd_sel_type;

   typedef enum logic [1:0] {
      RESP_PLAIN,
      RESP_READ_BAD,
      RESP_READ_DATA
   } resp_kind_type;

   typedef struct packed {
      logic                 capture;
      logic                 link_write;
      logic                 mem_we;
      wr_sel_type           wr_sel;
      logic                 rd_issue;
      rd_sel_type           rd_sel;
      logic                 cur_init;
      logic                 hop_clear_self;
      logic                 respond;
      logic                 resp_accepted;
      resp_kind_type        resp_kind;
      logic [NODE_BITS-1:0] dest_idx;
      logic [NODE_BITS-1:0] via_idx;
   } cmd_type;

   typedef struct packed {
      op_type               op;
      logic                 me_ok;
      logic                 node_ok;
      logic                 col_ok;
      logic                 nbr_ok;
      logic                 write_own;
      logic [CNT_BITS-1:0]  node_cnt;
      logic [NODE_BITS-1:0] me_idx;
   } status_type;

   function automatic logic [NODE_BITS-1:0] node_to_idx(input logic [FIELD_BITS-1:0] n);
      return NODE_BITS'(n - 5'd1);
   endfunction

   function automatic logic [HOP_BITS-1:0] hop_of(input logic [NODE_BITS-1:0] idx);
      return HOP_BITS'({1'b0, idx} + 1'b1);
   endfunction

   function automatic logic [ADDR_BITS-1:0] matrix_addr(input logic [NODE_BITS-1:0] row,
                                                        input logic [NODE_BITS-1:0] col);
      return {row, col};
   endfunction

   function automatic logic [COST_BITS-1:0] reset_cost(input logic [NODE_BITS-1:0] row,
                                                       input logic [NODE_BITS-1:0] col);
      return (row == col) ? '0 : COST_INF;
   endfunction

   function automatic logic in_range(input logic [FIELD_BITS-1:0] x,
                                     input logic [CNT_BITS-1:0] n);
      return (x != '0) && (int'(x) <= int'(n));
   endfunction

endpackage

`default_nettype wire

### hdl/dvru_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dvru_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

### hdl/dvru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dvru_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire dvru_pkg::status_type status,
   output      dvru_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CLEAR,
      S_D_START,
      S_ISSUE,
      S_DRAIN,
      S_WRITE_BACK,
      S_READ_WAIT
   } state_type;

   state_type                      state_ff;
   logic                           busy_ff;
   logic [dvru_pkg::CNT_BITS-1:0]  c_ff;
   logic [dvru_pkg::CNT_BITS-1:0]  v_ff;
   logic                           advert_ok;
   logic                           col_is_me;

   assign advert_ok = status.node_ok && status.col_ok && status.nbr_ok;
   assign col_is_me = (c_ff[dvru_pkg::NODE_BITS-1:0] == status.me_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         c_ff     <= '0;
         v_ff     <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_DECODE;
                  busy_ff  <= 1'b1;
               end
            end
            S_DECODE: begin
               case (status.op)
                  dvru_pkg::OP_RECOMPUTE: begin
                     if (status.me_ok) begin
                        state_ff <= S_CLEAR;
                        c_ff     <= '0;
                     end else begin
                        state_ff <= S_IDLE;
                        busy_ff  <= 1'b0;
                     end
                  end
                  dvru_pkg::OP_READ_ROUTE: begin
                     if (status.me_ok && status.node_ok) begin
                        state_ff <= S_READ_WAIT;
                     end else begin
                        state_ff <= S_IDLE;
                        busy_ff  <= 1'b0;
                     end
                  end
                  default: begin
                     state_ff <= S_IDLE;
                     busy_ff  <= 1'b0;
                  end
               endcase
            end
            S_CLEAR: begin
               if (c_ff == status.node_cnt - 1'b1) begin
                  c_ff     <= '0;
                  state_ff <= S_D_START;
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            S_D_START: begin
               if (c_ff == status.node_cnt) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end else if (col_is_me) begin
                  c_ff <= c_ff + 1'b1;
               end else begin
                  v_ff     <= '0;
                  state_ff <= S_ISSUE;
               end
            end
            S_ISSUE: begin
               if (v_ff == status.node_cnt - 1'b1) begin
                  state_ff <= S_DRAIN;
               end else begin
                  v_ff <= v_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_WRITE_BACK;
            end
            S_WRITE_BACK: begin
               c_ff     <= c_ff + 1'b1;
               state_ff <= S_D_START;
            end
            S_READ_WAIT: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd                = '0;
      cmd.wr_sel         = dvru_pkg::WR_SET_LINK;
      cmd.rd_sel         = dvru_pkg::RD_ROUTE;
      cmd.resp_kind      = dvru_pkg::RESP_PLAIN;
      cmd.dest_idx       = c_ff[dvru_pkg::NODE_BITS-1:0];
      cmd.via_idx        = v_ff[dvru_pkg::NODE_BITS-1:0];
      cmd.capture        = start && !busy_ff;
      case (state_ff)
         S_DECODE: begin
            case (status.op)
               dvru_pkg::OP_SET_LINK: begin
                  cmd.link_write    = status.node_ok;
                  cmd.mem_we        = status.node_ok && status.write_own && status.me_ok;
                  cmd.wr_sel        = dvru_pkg::WR_SET_LINK;
                  cmd.respond       = 1'b1;
                  cmd.resp_accepted = status.node_ok;
               end
               dvru_pkg::OP_STORE_ADVERT: begin
                  cmd.mem_we        = advert_ok;
                  cmd.wr_sel        = dvru_pkg::WR_ADVERT;
                  cmd.respond       = 1'b1;
                  cmd.resp_accepted = advert_ok;
               end
               dvru_pkg::OP_RECOMPUTE: begin
                  cmd.respond = !status.me_ok;
               end
               dvru_pkg::OP_READ_ROUTE: begin
                  if (status.me_ok && status.node_ok) begin
                     cmd.rd_issue = 1'b1;
                     cmd.rd_sel   = dvru_pkg::RD_ROUTE;
                  end else begin
                     cmd.respond   = 1'b1;
                     cmd.resp_kind = dvru_pkg::RESP_READ_BAD;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         S_CLEAR: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = dvru_pkg::WR_CLEAR;
         end
         S_D_START: begin
            if (c_ff == status.node_cnt) begin
               cmd.respond       = 1'b1;
               cmd.resp_accepted = 1'b1;
            end else if (col_is_me) begin
               cmd.hop_clear_self = 1'b1;
            end else begin
               cmd.cur_init = 1'b1;
            end
         end
         S_ISSUE: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = dvru_pkg::RD_RELAX;
         end
         S_WRITE_BACK: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = dvru_pkg::WR_BACK;
         end
         S_READ_WAIT: begin
            cmd.respond       = 1'b1;
            cmd.resp_accepted = 1'b1;
            cmd.resp_kind     = dvru_pkg::RESP_READ_DATA;
         end
         default: begin
         end
      endcase
   end

   assign busy = busy_ff;

   // every operation ends with exactly one response
   a_busy_fall_has_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(cmd.respond))
      else $error("busy dropped without a response");

   a_via_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ISSUE) |-> (v_ff < status.node_cnt))
      else $error("via counter beyond node count");

   a_clear_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (c_ff < status.node_cnt))
      else $error("clear column beyond node count");

endmodule

`default_nettype wire

### hdl/dvru_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dvru_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dvru_pkg::cmd_type                     cmd,
   output      dvru_pkg::status_type                  status,
   input  wire logic [dvru_pkg::OP_BITS-1:0]          req_operation,
   input  wire logic [dvru_pkg::FIELD_BITS-1:0]       req_node,
   input  wire logic [dvru_pkg::FIELD_BITS-1:0]       req_column_node,
   input  wire logic [dvru_pkg::COST_BITS-1:0]        req_cost,
   input  wire logic                                  req_is_neighbor,
   input  wire logic                                  req_write_own_row,
   input  wire logic                                  csr_write_enable,
   input  wire logic [dvru_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [dvru_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output      logic                                  rsp_strobe,
   output      logic                                  rsp_accepted,
   output      logic [dvru_pkg::COST_BITS-1:0]        rsp_route_cost,
   output      logic [dvru_pkg::HOP_BITS-1:0]         rsp_next_hop
);

   localparam int NB = dvru_pkg::NODE_BITS;
   localparam int CB = dvru_pkg::COST_BITS;

   // configuration
   logic [dvru_pkg::FIELD_BITS-1:0] my_index_ff;
   logic [dvru_pkg::FIELD_BITS-1:0] node_count_ff;
   logic [CB-1:0]                   cost_cap_ff;

   // captured request
   logic [dvru_pkg::OP_BITS-1:0]    op_ff;
   logic [dvru_pkg::FIELD_BITS-1:0] node_ff;
   logic [dvru_pkg::FIELD_BITS-1:0] col_ff;
   logic [CB-1:0]                   cost_ff;
   logic                            nbr_ff;
   logic                            own_ff;

   // per-node state
   logic [CB-1:0]                   link_ff [dvru_pkg::MAX_NODES];
   logic                            flag_ff [dvru_pkg::MAX_NODES];
   logic [dvru_pkg::HOP_BITS-1:0]   hop_ff  [dvru_pkg::MAX_NODES];
   logic [dvru_pkg::MATRIX_DEPTH-1:0] valid_ff;

   // read pipeline
   logic                            va_ff;
   logic                            vb_ff;
   logic [CB-1:0]                   rst_a_ff;
   logic [CB-1:0]                   rst_b_ff;
   logic [NB-1:0]                   via_p_ff;
   logic                            relax_vld_ff;
   logic [CB-1:0]                   cur_ff;

   // response
   logic                            rsp_strobe_ff;
   logic                            rsp_accepted_ff;
   logic [CB-1:0]                   rsp_route_cost_ff;
   logic [dvru_pkg::HOP_BITS-1:0]   rsp_next_hop_ff;

   logic [dvru_pkg::CNT_BITS-1:0]   node_cnt;
   logic [NB-1:0]                   me_idx;
   logic [NB-1:0]                   node_idx;
   logic [NB-1:0]                   col_idx;

   logic [dvru_pkg::ADDR_BITS-1:0]  wr_addr;
   logic [CB-1:0]                   wr_data;
   logic [dvru_pkg::ADDR_BITS-1:0]  rd_addr_a;
   logic [dvru_pkg::ADDR_BITS-1:0]  rd_addr_b;
   logic [NB-1:0]                   rd_row_a;
   logic [NB-1:0]                   rd_col_a;
   logic [NB-1:0]                   rd_row_b;
   logic [NB-1:0]                   rd_col_b;
   logic [CB-1:0]                   ram_a;
   logic [CB-1:0]                   ram_b;
   logic [CB-1:0]                   a_val;
   logic [CB-1:0]                   b_val;

   logic [CB-1:0]                   term_a;
   logic [CB-1:0]                   term_b;
   logic [dvru_pkg::SUM_BITS-1:0]   sum;
   logic [dvru_pkg::SUM_BITS-1:0]   lk;
   logic                            lk_wins;
   logic [dvru_pkg::SUM_BITS-1:0]   best;
   logic                            improve;
   logic [CB-1:0]                   new_cost;
   logic [dvru_pkg::HOP_BITS-1:0]   new_hop;

   assign node_cnt = (int'(node_count_ff) > dvru_pkg::MAX_NODES)
                     ? dvru_pkg::CNT_BITS'(dvru_pkg::MAX_NODES)
                     : dvru_pkg::CNT_BITS'(node_count_ff);
   assign me_idx   = dvru_pkg::node_to_idx(my_index_ff);
   assign node_idx = dvru_pkg::node_to_idx(node_ff);
   assign col_idx  = dvru_pkg::node_to_idx(col_ff);

   always_comb begin
      status.op        = dvru_pkg::op_type'(op_ff);
      status.me_ok     = dvru_pkg::in_range(my_index_ff, node_cnt);
      status.node_ok   = dvru_pkg::in_range(node_ff, node_cnt);
      status.col_ok    = dvru_pkg::in_range(col_ff, node_cnt);
      status.nbr_ok    = flag_ff[node_idx];
      status.write_own = own_ff;
      status.node_cnt  = node_cnt;
      status.me_idx    = me_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_index_ff   <= dvru_pkg::MY_INDEX_RESET;
         node_count_ff <= dvru_pkg::NODE_COUNT_RESET;
         cost_cap_ff   <= dvru_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            dvru_pkg::CSR_MY_INDEX:   my_index_ff   <= csr_data[dvru_pkg::FIELD_BITS-1:0];
            dvru_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data[dvru_pkg::FIELD_BITS-1:0];
            dvru_pkg::CSR_COST_CAP:   cost_cap_ff   <= csr_data[CB-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         node_ff <= req_node;
         col_ff  <= req_column_node;
         cost_ff <= req_cost;
         nbr_ff  <= req_is_neighbor;
         own_ff  <= req_write_own_row;
      end
   end

   // matrix write and read addressing
   always_comb begin
      case (cmd.wr_sel)
         dvru_pkg::WR_SET_LINK: begin
            wr_addr = dvru_pkg::matrix_addr(me_idx, node_idx);
            wr_data = cost_ff;
         end
         dvru_pkg::WR_ADVERT: begin
            wr_addr = dvru_pkg::matrix_addr(node_idx, col_idx);
            wr_data = cost_ff;
         end
         dvru_pkg::WR_CLEAR: begin
            wr_addr = dvru_pkg::matrix_addr(me_idx, cmd.dest_idx);
            wr_data = dvru_pkg::reset_cost(me_idx, cmd.dest_idx);
         end
         dvru_pkg::WR_BACK: begin
            wr_addr = dvru_pkg::matrix_addr(me_idx, cmd.dest_idx);
            wr_data = cur_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = '0;
         end
      endcase

      case (cmd.rd_sel)
         dvru_pkg::RD_RELAX: begin
            rd_row_a = me_idx;
            rd_col_a = cmd.via_idx;
            rd_row_b = cmd.via_idx;
            rd_col_b = cmd.dest_idx;
         end
         default: begin
            rd_row_a = me_idx;
            rd_col_a = node_idx;
            rd_row_b = me_idx;
            rd_col_b = node_idx;
         end
      endcase
      rd_addr_a = dvru_pkg::matrix_addr(rd_row_a, rd_col_a);
      rd_addr_b = dvru_pkg::matrix_addr(rd_row_b, rd_col_b);
   end

   dvru_ram #(
      .WIDTH (CB),
      .DEPTH (dvru_pkg::MATRIX_DEPTH)
   ) u_matrix (
      .clock     (clock),
      .wr_en     (cmd.mem_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ram_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (ram_b)
   );

   // entries never written read as the reset matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      va_ff    <= valid_ff[rd_addr_a];
      vb_ff    <= valid_ff[rd_addr_b];
      rst_a_ff <= dvru_pkg::reset_cost(rd_row_a, rd_col_a);
      rst_b_ff <= dvru_pkg::reset_cost(rd_row_b, rd_col_b);
      via_p_ff <= cmd.via_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_vld_ff <= 1'b0;
      end else begin
         relax_vld_ff <= cmd.rd_issue && (cmd.rd_sel == dvru_pkg::RD_RELAX);
      end
   end

   assign a_val = va_ff ? ram_a : rst_a_ff;
   assign b_val = vb_ff ? ram_b : rst_b_ff;

   // relaxation step: own[d] is held in cur_ff for the whole via sweep
   always_comb begin
      term_a   = (via_p_ff == cmd.dest_idx) ? cur_ff : a_val;
      term_b   = (via_p_ff == me_idx) ? cur_ff : b_val;
      sum      = {1'b0, term_a} + {1'b0, term_b};
      lk       = {1'b0, link_ff[cmd.dest_idx]};
      lk_wins  = (lk < sum);
      best     = lk_wins ? lk : sum;
      improve  = ({1'b0, cur_ff} > best);
      if (best > {1'b0, cost_cap_ff}) begin
         new_cost = dvru_pkg::COST_INF;
         new_hop  = '0;
      end else begin
         new_cost = best[CB-1:0];
         new_hop  = lk_wins ? dvru_pkg::hop_of(cmd.dest_idx) : dvru_pkg::hop_of(via_p_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cur_init) begin
         cur_ff <= dvru_pkg::COST_INF;
      end else if (relax_vld_ff && improve) begin
         cur_ff <= new_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dvru_pkg::MAX_NODES; i++) begin
            link_ff[i] <= dvru_pkg::COST_INF;
            flag_ff[i] <= 1'b0;
            hop_ff[i]  <= '0;
         end
      end else begin
         if (cmd.link_write) begin
            link_ff[node_idx] <= cost_ff;
            flag_ff[node_idx] <= nbr_ff;
         end
         if (cmd.hop_clear_self) begin
            hop_ff[cmd.dest_idx] <= '0;
         end else if (relax_vld_ff && improve) begin
            hop_ff[cmd.dest_idx] <= new_hop;
         end else if (cmd.respond && (cmd.resp_kind == dvru_pkg::RESP_READ_DATA)
                      && (a_val == dvru_pkg::COST_INF)) begin
            hop_ff[node_idx] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_accepted_ff <= cmd.resp_accepted;
         case (cmd.resp_kind)
            dvru_pkg::RESP_READ_BAD: begin
               rsp_route_cost_ff <= dvru_pkg::COST_INF;
               rsp_next_hop_ff   <= '0;
            end
            dvru_pkg::RESP_READ_DATA: begin
               rsp_route_cost_ff <= a_val;
               rsp_next_hop_ff   <= (a_val == dvru_pkg::COST_INF) ? '0 : hop_ff[node_idx];
            end
            default: begin
               rsp_route_cost_ff <= '0;
               rsp_next_hop_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_route_cost = rsp_route_cost_ff;
   assign rsp_next_hop   = rsp_next_hop_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two responses in consecutive cycles");

   // write-back must wait for the last relaxation step
   a_drain_before_back: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_we && (cmd.wr_sel == dvru_pkg::WR_BACK)) |-> !relax_vld_ff)
      else $error("own row written back while relaxation pending");

   a_inf_no_hop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_route_cost_ff == dvru_pkg::COST_INF)) |-> (rsp_next_hop_ff == '0))
      else $error("next hop given for an infinite route");

endmodule

`default_nettype wire

### hdl/distance_vector_route_update.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    | ports                                            | transfer
// -----------+--------------------------------------------------+---------------------------
// request    | start, busy, req_operation .. req_write_own_row  | start high, busy low
// response   | rsp_strobe, rsp_accepted, rsp_route_cost, ...    | rsp_strobe high, one cycle
// csr write  | csr_write_enable, csr_index, csr_data            | csr_write_enable high
//
// set link and store advert answer from the decode state; read route answers after its ram read.
// recompute clears the own row, then sweeps each destination but self through every via and writes it back:
// the relaxation sweep reads one matrix pair per cycle through the two read ports of the ram.
// reset is synchronous; per-entry valid bits give the reset matrix, so reset needs no clearing pass.
// the response cannot be stalled; busy stays high until the response is issued.

module distance_vector_route_update (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [dvru_pkg::OP_BITS-1:0]        req_operation,
   input  wire logic [dvru_pkg::FIELD_BITS-1:0]     req_node,
   input  wire logic [dvru_pkg::FIELD_BITS-1:0]     req_column_node,
   input  wire logic [dvru_pkg::COST_BITS-1:0]      req_cost,
   input  wire logic                                req_is_neighbor,
   input  wire logic                                req_write_own_row,
   output      logic                                rsp_strobe,
   output      logic                                rsp_accepted,
   output      logic [dvru_pkg::COST_BITS-1:0]      rsp_route_cost,
   output      logic [dvru_pkg::HOP_BITS-1:0]       rsp_next_hop,
   input  wire logic                                csr_write_enable,
   input  wire logic [dvru_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [dvru_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   dvru_pkg::cmd_type    cmd;
   dvru_pkg::status_type status;

   dvru_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   dvru_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_node          (req_node),
      .req_column_node   (req_column_node),
      .req_cost          (req_cost),
      .req_is_neighbor   (req_is_neighbor),
      .req_write_own_row (req_write_own_row),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted),
      .rsp_route_cost    (rsp_route_cost),
      .rsp_next_hop      (rsp_next_hop)
   );

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int LIMIT_CYCLES = 3_000_000;

   typedef struct {
      dvru_pkg::op_type                op;
      logic [dvru_pkg::FIELD_BITS-1:0] node;
      logic [dvru_pkg::FIELD_BITS-1:0] col;
      logic [dvru_pkg::COST_BITS-1:0]  cost;
      logic                            nbr;
      logic                            own;
   } route_request_type;

   typedef struct {
      logic                           accepted;
      logic [dvru_pkg::COST_BITS-1:0] cost;
      logic [dvru_pkg::HOP_BITS-1:0]  hop;
   } route_answer_type;

   // own copy of the route tables; predicts each answer as a request is taken
   class route_predictor_type;
      logic [dvru_pkg::COST_BITS-1:0] costs [dvru_pkg::MAX_NODES][dvru_pkg::MAX_NODES];
      logic [dvru_pkg::COST_BITS-1:0] link_costs [dvru_pkg::MAX_NODES];
      logic                           neighbours [dvru_pkg::MAX_NODES];
      logic [dvru_pkg::HOP_BITS-1:0]  hops [dvru_pkg::MAX_NODES];
      int unsigned                    my_index;
      int unsigned                    node_count;
      int unsigned                    cost_cap;
      route_answer_type               awaited [$];
      int                             mismatches;

      function new();
         for (int r = 0; r < dvru_pkg::MAX_NODES; r++) begin
            for (int c = 0; c < dvru_pkg::MAX_NODES; c++) begin
               costs[r][c] = (r == c) ? '0 : dvru_pkg::COST_INF;
            end
            link_costs[r] = dvru_pkg::COST_INF;
            neighbours[r] = 1'b0;
            hops[r] = '0;
         end
         my_index = dvru_pkg::MY_INDEX_RESET;
         node_count = dvru_pkg::NODE_COUNT_RESET;
         cost_cap = dvru_pkg::CAP_RESET;
         mismatches = 0;
      endfunction

      function int unsigned live_nodes();
         return (node_count > dvru_pkg::MAX_NODES) ? dvru_pkg::MAX_NODES : node_count;
      endfunction

      function bit valid_node(int unsigned x);
         return (x >= 1) && (x <= live_nodes());
      endfunction

      function void set_register(logic [dvru_pkg::CSR_IDX_BITS-1:0] idx, int unsigned value);
         case (idx)
            dvru_pkg::CSR_MY_INDEX:   my_index = value & 31;
            dvru_pkg::CSR_NODE_COUNT: node_count = value & 31;
            dvru_pkg::CSR_COST_CAP:   cost_cap = value & 16'hFFFF;
            default: ;
         endcase
      endfunction

      // clear own row, then relax each destination through every via, in place
      function void rebuild_own_row(int unsigned me);
         int unsigned n, prev, s, lk, m, nv;
         n = live_nodes();
         for (int unsigned d = 0; d < n; d++) begin
            costs[me][d] = (d == me) ? '0 : dvru_pkg::COST_INF;
         end
         for (int unsigned d = 0; d < n; d++) begin
            if (d == me) begin
               hops[d] = '0;
               continue;
            end
            for (int unsigned v = 0; v < n; v++) begin
               prev = costs[me][d];
               s = 32'(costs[me][v]) + 32'(costs[v][d]);
               lk = link_costs[d];
               m = (lk < s) ? lk : s;
               if (prev > m) begin
                  if (lk < s) begin
                     nv = lk;
                     hops[d] = dvru_pkg::HOP_BITS'(d + 1);
                  end else begin
                     nv = s;
                     hops[d] = dvru_pkg::HOP_BITS'(v + 1);
                  end
                  if (nv > cost_cap) begin
                     nv = dvru_pkg::COST_INF;
                     hops[d] = '0;
                  end
                  costs[me][d] = dvru_pkg::COST_BITS'(nv);
               end
            end
         end
      endfunction

      function void note_request(route_request_type q);
         route_answer_type a;
         bit               me_ok;
         int unsigned      me, node, col;
         a.accepted = 1'b0;
         a.cost = '0;
         a.hop = '0;
         me_ok = valid_node(my_index);
         me = my_index - 1;
         node = q.node;
         col = q.col;
         case (q.op)
            dvru_pkg::OP_SET_LINK: begin
               if (valid_node(node)) begin
                  link_costs[node-1] = q.cost;
                  neighbours[node-1] = q.nbr;
                  if (q.own && me_ok) costs[me][node-1] = q.cost;
                  a.accepted = 1'b1;
               end
            end
            dvru_pkg::OP_STORE_ADVERT: begin
               if (valid_node(node) && valid_node(col) && neighbours[node-1]) begin
                  costs[node-1][col-1] = q.cost;
                  a.accepted = 1'b1;
               end
            end
            dvru_pkg::OP_RECOMPUTE: begin
               if (me_ok) begin
                  rebuild_own_row(me);
                  a.accepted = 1'b1;
               end
            end
            default: begin
               a.cost = dvru_pkg::COST_INF;
               if (me_ok && valid_node(node)) begin
                  a.cost = costs[me][node-1];
                  if (a.cost == dvru_pkg::COST_INF) hops[node-1] = '0;
                  a.hop = hops[node-1];
                  a.accepted = 1'b1;
               end
            end
         endcase
         awaited.push_back(a);
      endfunction

      function void report(string field, int unsigned want, logic [31:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_answer(logic acc, logic [dvru_pkg::COST_BITS-1:0] cost,
                                 logic [dvru_pkg::HOP_BITS-1:0] hop);
         route_answer_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: answer with no request outstanding, actual %0d %0d %0d",
                     $time, acc, cost, hop);
            return;
         end
         want = awaited.pop_front();
         if (acc !== want.accepted) report("accepted", want.accepted, 32'(acc));
         if (cost !== want.cost) report("route_cost", want.cost, 32'(cost));
         if (hop !== want.hop) report("next_hop", want.hop, 32'(hop));
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [dvru_pkg::OP_BITS-1:0]       req_operation;
   logic [dvru_pkg::FIELD_BITS-1:0]    req_node;
   logic [dvru_pkg::FIELD_BITS-1:0]    req_column_node;
   logic [dvru_pkg::COST_BITS-1:0]     req_cost;
   logic                               req_is_neighbor;
   logic                               req_write_own_row;
   logic                               rsp_strobe;
   logic                               rsp_accepted;
   logic [dvru_pkg::COST_BITS-1:0]     rsp_route_cost;
   logic [dvru_pkg::HOP_BITS-1:0]      rsp_next_hop;
   logic                               csr_write_enable;
   logic [dvru_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [dvru_pkg::CSR_DATA_BITS-1:0] csr_data;

   route_predictor_type routes = new();
   bit                  no_idle;
   int                  cycles = 0;

   int phase_me    [11] = '{1, 5, 16, 3, 2, 0, 10, 1, 7, 12, 0};
   int phase_count [11] = '{16, 8, 16, 4, 2, 16, 6, 1, 31, 0, 0};
   int phase_cap   [11] = '{100, 65534, 0, 50, 200, 100, 100, 100, 1000, 100, 0};

   distance_vector_route_update DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_node          (req_node),
      .req_column_node   (req_column_node),
      .req_cost          (req_cost),
      .req_is_neighbor   (req_is_neighbor),
      .req_write_own_row (req_write_own_row),
      .rsp_strobe        (rsp_strobe),
      .rsp_accepted      (rsp_accepted),
      .rsp_route_cost    (rsp_route_cost),
      .rsp_next_hop      (rsp_next_hop),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         routes.check_answer(rsp_accepted, rsp_route_cost, rsp_next_hop);
      end
   end

   // one request; the transfer happens at the first rising edge with busy low
   task automatic issue(dvru_pkg::op_type op, int node, int col, int cost, bit nbr, bit own);
      route_request_type q;
      int                gap;
      q.op = op;
      q.node = dvru_pkg::FIELD_BITS'(node);
      q.col = dvru_pkg::FIELD_BITS'(col);
      q.cost = dvru_pkg::COST_BITS'(cost);
      q.nbr = nbr;
      q.own = own;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= q.op;
      req_node <= q.node;
      req_column_node <= q.col;
      req_cost <= q.cost;
      req_is_neighbor <= q.nbr;
      req_write_own_row <= q.own;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      routes.note_request(q);
   endtask

   task automatic wait_for_answers();
      @(negedge clock);
      start <= 1'b0;
      while (routes.awaited.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic csr_write(logic [dvru_pkg::CSR_IDX_BITS-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= dvru_pkg::CSR_DATA_BITS'(value);
      routes.set_register(idx, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic int pick_node();
      int n;
      n = routes.live_nodes();
      if (n > 0 && $urandom_range(0, 99) < 85) return $urandom_range(1, n);
      return $urandom_range(0, 31);
   endfunction

   // mostly small costs so that routes stay under the cap and get relaxed
   function automatic int pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 30);
      if (r < 55) return $urandom_range(0, 200);
      if (r < 68) return dvru_pkg::COST_INF;
      if (r < 78) return $urandom_range(0, 1) ? routes.cost_cap : routes.cost_cap + 1;
      if (r < 82) return 65534;
      return $urandom_range(0, 65535);
   endfunction

   task automatic random_request();
      dvru_pkg::op_type op;
      int               r;
      r = $urandom_range(0, 99);
      if (r < 25) op = dvru_pkg::OP_SET_LINK;
      else if (r < 60) op = dvru_pkg::OP_STORE_ADVERT;
      else if (r < 68) op = dvru_pkg::OP_RECOMPUTE;
      else op = dvru_pkg::OP_READ_ROUTE;
      issue(op, pick_node(), pick_node(), pick_cost(),
            $urandom_range(0, 99) < 75, $urandom_range(0, 1));
   endtask

   initial begin
      int items;
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_node = '0;
      req_column_node = '0;
      req_cost = '0;
      req_is_neighbor = 1'b0;
      req_write_own_row = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_idle = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings: node 1 routes to 4 through 2, cap cuts a 101 path
      issue(dvru_pkg::OP_READ_ROUTE, 2, 0, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 1, 0, 0, 0, 0);
      issue(dvru_pkg::OP_SET_LINK, 2, 0, 5, 1, 1);
      issue(dvru_pkg::OP_SET_LINK, 3, 0, 40, 1, 0);
      issue(dvru_pkg::OP_SET_LINK, 16, 0, 65535, 0, 1);
      issue(dvru_pkg::OP_SET_LINK, 0, 0, 7, 1, 1);
      issue(dvru_pkg::OP_SET_LINK, 17, 0, 7, 1, 1);
      issue(dvru_pkg::OP_STORE_ADVERT, 16, 4, 1, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 4, 7, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 3, 4, 1, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 16, 0, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 5, 65535, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 6, 94, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 7, 96, 0, 0);
      issue(dvru_pkg::OP_STORE_ADVERT, 2, 0, 3, 0, 0);
      issue(dvru_pkg::OP_RECOMPUTE, 1, 1, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 4, 0, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 16, 0, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 7, 0, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 0, 0, 0, 0, 0);
      issue(dvru_pkg::OP_SET_LINK, 3, 0, 2, 0, 1);
      issue(dvru_pkg::OP_RECOMPUTE, 1, 1, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 4, 0, 0, 0, 0);
      issue(dvru_pkg::OP_READ_ROUTE, 31, 31, 65535, 1, 1);
      issue(dvru_pkg::OP_SET_LINK, 4, 0, 65534, 1, 1);

      for (int p = 0; p < 11; p++) begin
         wait_for_answers();
         if (p == 10) begin
            phase_me[p] = $urandom_range(1, 16);
            phase_count[p] = $urandom_range(1, 16);
            phase_cap[p] = $urandom_range(0, 65534);
         end
         csr_write(dvru_pkg::CSR_MY_INDEX, phase_me[p]);
         csr_write(dvru_pkg::CSR_NODE_COUNT, phase_count[p]);
         csr_write(dvru_pkg::CSR_COST_CAP, phase_cap[p]);
         no_idle = (p % 3 == 1);
         items = (phase_count[p] == 0) ? 30 : 150;
         for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 99) == 0) wait_for_answers();
            random_request();
         end
      end

      wait_for_answers();
      repeat (20) @(posedge clock);
      if (routes.mismatches == 0 && routes.awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### distance_vector_route_update.f
hdl/dvru_pkg.sv
hdl/dvru_ram.sv
hdl/dvru_ctrl.sv
hdl/dvru_datapath.sv
hdl/distance_vector_route_update.sv
dv/tb_top.sv
